FILE: sv/zoom_stepper_positioner_unit_macros.svh
// Assertion macros shared by the zoom stepper positioner modules.
// Each macro expects clk and rst_n to be visible in the module that uses it.
`ifndef ZOOM_STEPPER_POSITIONER_UNIT_MACROS_SVH
`define ZOOM_STEPPER_POSITIONER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ZSP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ZSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/zsp_pkg.sv
// Package for the zoom stepper positioner: payload types, tables and constants.
// No dependencies; used by zsp_table_lookup and the top level.
package zsp_pkg;

  localparam int TABLE_MAX = 16;

  localparam logic [10:0] COORD_TAB [TABLE_MAX] = '{
    11'd40, 11'd108, 11'd182, 11'd398, 11'd614, 11'd856, 11'd910, 11'd1000,
    11'd1020, 11'd1040, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0
  };

  localparam logic [7:0] FOCAL_TAB [TABLE_MAX] = '{
    8'd20, 8'd24, 8'd28, 8'd35, 8'd50, 8'd70, 8'd80, 8'd105,
    8'd135, 8'd200, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
  };

  localparam logic [7:0] PAT_FWD [4] = '{8'h10, 8'h14, 8'h04, 8'h00};
  localparam logic [7:0] PAT_BWD [4] = '{8'h00, 8'h04, 8'h14, 8'h10};

  localparam logic [10:0] HOME_COORD_RST = 11'd1040;
  localparam logic [10:0] STEP_LIMIT_RST = 11'd1060;
  localparam logic [10:0] COUNT_MAX      = 11'd2047;
  localparam logic [7:0]  FOCAL_ALIAS    = 8'd14;
  localparam logic [7:0]  HOME_FOCAL     = 8'd200;

  localparam logic [0:0] CFG_HOME_COORD = 1'd0;
  localparam logic [0:0] CFG_STEP_LIMIT = 1'd1;

  typedef struct packed {
    logic       set_dest;
    logic [7:0] dest_focal;
    logic       reset_cmd;
    logic       home_switch;
  } zsp_in_t;

  typedef struct packed {
    logic       coil_a;
    logic       coil_b;
    logic       driver_enable;
    logic       charge_inhibit;
    logic       busy_res;
    logic       homed;
    logic       fault;
    logic [7:0] location;
  } zsp_out_t;

endpackage

FILE: sv/zoom_stepper_positioner_unit.sv
// Zoom stepper positioner top level: state update, motor drive and result register.
// Depends on zsp_pkg, zsp_table_lookup and zoom_stepper_positioner_unit_macros.svh.
// The result of an item is registered and valid in the cycle after the item is accepted.
// Throughput: one item per cycle while the output is not stalled; the single-pass state update sets this figure.
// Reset (synchronous, rst_n low) clears all motion state and the result register
// valid, and loads the home coordinate with 1040 and the homing step limit with 1060.
`include "zoom_stepper_positioner_unit_macros.svh"

module zoom_stepper_positioner_unit
  import zsp_pkg::*;
#(
  parameter int TABLE_ENTRIES = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  zsp_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output zsp_out_t    out_data,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  logic [10:0] home_coord_r, step_limit_r;
  logic        homed_flag_r, motor_active_r, fault_flag_r, step_dir_r;
  logic        charge_locked_r, move_announced_r;
  logic [7:0]  current_focal_r, target_focal_r;
  logic [10:0] position_r, steps_left_r, homing_count_r;
  logic [1:0]  phase_r;

  logic        homed_flag_nxt, motor_active_nxt, fault_flag_nxt, step_dir_nxt;
  logic        charge_locked_nxt, move_announced_nxt;
  logic [7:0]  current_focal_nxt, target_focal_nxt;
  logic [10:0] position_nxt, steps_left_nxt, homing_count_nxt;
  logic [1:0]  phase_nxt;

  logic        hf_a, ma_a, cl_a, dir_a;
  logic [7:0]  cf_a, tf_a;
  logic [10:0] hc_a;

  logic        org_hit, dst_hit;
  logic [10:0] org_coord, dst_coord, origin;

  logic        out_valid_r;
  zsp_out_t    out_r, out_nxt;
  logic        accept;
  logic [7:0]  pat;

  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Destination load and reset command.
  always_comb begin
    tf_a  = in_data.set_dest ? in_data.dest_focal : target_focal_r;
    cf_a  = current_focal_r;
    hf_a  = homed_flag_r;
    hc_a  = homing_count_r;
    cl_a  = charge_locked_r;
    dir_a = step_dir_r;
    ma_a  = motor_active_r;
    if (in_data.reset_cmd) begin
      hc_a = '0;
      if (!in_data.home_switch) begin
        hf_a = 1'b1;
        cf_a = HOME_FOCAL;
      end else begin
        hf_a  = 1'b0;
        cl_a  = 1'b1;
        dir_a = 1'b0;
        ma_a  = 1'b1;
      end
    end
  end

  zsp_table_lookup #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_org_lookup (
    .focal (cf_a),
    .hit   (org_hit),
    .coord (org_coord)
  );

  zsp_table_lookup #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dst_lookup (
    .focal (tf_a),
    .hit   (dst_hit),
    .coord (dst_coord)
  );

  assign origin = (cf_a == 8'd0) ? position_r : org_coord;

  // Move planning and motor drive.
  always_comb begin
    homed_flag_nxt     = hf_a;
    motor_active_nxt   = ma_a;
    fault_flag_nxt     = fault_flag_r;
    step_dir_nxt       = dir_a;
    charge_locked_nxt  = cl_a;
    move_announced_nxt = move_announced_r;
    current_focal_nxt  = cf_a;
    target_focal_nxt   = tf_a;
    position_nxt       = position_r;
    steps_left_nxt     = steps_left_r;
    homing_count_nxt   = hc_a;
    phase_nxt          = phase_r;
    pat                = 8'h00;
    out_nxt            = '0;

    if (!ma_a) begin
      if (cf_a == tf_a) begin
        if (move_announced_r) begin
          charge_locked_nxt  = 1'b0;
          move_announced_nxt = 1'b0;
        end
      end else begin
        if (!move_announced_r) begin
          charge_locked_nxt  = 1'b1;
          move_announced_nxt = 1'b1;
        end
        if (cf_a != 8'd0 && !org_hit) begin
          homing_count_nxt  = '0;
          charge_locked_nxt = 1'b0;
          if (!in_data.home_switch) begin
            homed_flag_nxt    = 1'b1;
            current_focal_nxt = HOME_FOCAL;
          end else begin
            homed_flag_nxt   = 1'b0;
            step_dir_nxt     = 1'b0;
            motor_active_nxt = 1'b1;
          end
        end else if (!dst_hit) begin
          target_focal_nxt  = cf_a;
          charge_locked_nxt = 1'b0;
        end else begin
          if (dst_coord > origin) begin
            step_dir_nxt   = 1'b0;
            steps_left_nxt = dst_coord - origin;
          end else begin
            step_dir_nxt   = 1'b1;
            steps_left_nxt = origin - dst_coord;
          end
          motor_active_nxt = 1'b1;
        end
      end
    end

    if (motor_active_nxt && !fault_flag_r) begin
      if (!homed_flag_nxt) begin
        out_nxt.driver_enable = 1'b1;
        if (!in_data.home_switch) begin
          homed_flag_nxt    = 1'b1;
          current_focal_nxt = HOME_FOCAL;
          position_nxt      = home_coord_r;
          homing_count_nxt  = '0;
          motor_active_nxt  = 1'b0;
          charge_locked_nxt = 1'b0;
        end else begin
          pat       = PAT_FWD[phase_r];
          phase_nxt = phase_r + 2'd1;
          if (homing_count_nxt > step_limit_r) begin
            fault_flag_nxt    = 1'b1;
            charge_locked_nxt = 1'b0;
          end
          if (homing_count_nxt != COUNT_MAX) begin
            homing_count_nxt = homing_count_nxt + 11'd1;
          end
        end
      end else if (steps_left_nxt != 11'd0) begin
        steps_left_nxt        = steps_left_nxt - 11'd1;
        out_nxt.driver_enable = 1'b1;
        pat                   = step_dir_nxt ? PAT_BWD[phase_r] : PAT_FWD[phase_r];
        phase_nxt             = phase_r + 2'd1;
      end else begin
        current_focal_nxt = target_focal_nxt;
        motor_active_nxt  = 1'b0;
        charge_locked_nxt = 1'b0;
      end
    end

    out_nxt.coil_a         = pat[4];
    out_nxt.coil_b         = pat[2];
    out_nxt.charge_inhibit = charge_locked_nxt;
    out_nxt.busy_res       = motor_active_nxt && !fault_flag_nxt;
    out_nxt.homed          = homed_flag_nxt;
    out_nxt.fault          = fault_flag_nxt;
    out_nxt.location       = current_focal_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      home_coord_r <= HOME_COORD_RST;
      step_limit_r <= STEP_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HOME_COORD: home_coord_r <= cfg_data;
        CFG_STEP_LIMIT: step_limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      homed_flag_r     <= 1'b0;
      motor_active_r   <= 1'b0;
      fault_flag_r     <= 1'b0;
      step_dir_r       <= 1'b0;
      charge_locked_r  <= 1'b0;
      move_announced_r <= 1'b0;
      current_focal_r  <= '0;
      target_focal_r   <= '0;
      position_r       <= '0;
      steps_left_r     <= '0;
      homing_count_r   <= '0;
      phase_r          <= '0;
    end else if (accept) begin
      homed_flag_r     <= homed_flag_nxt;
      motor_active_r   <= motor_active_nxt;
      fault_flag_r     <= fault_flag_nxt;
      step_dir_r       <= step_dir_nxt;
      charge_locked_r  <= charge_locked_nxt;
      move_announced_r <= move_announced_nxt;
      current_focal_r  <= current_focal_nxt;
      target_focal_r   <= target_focal_nxt;
      position_r       <= position_nxt;
      steps_left_r     <= steps_left_nxt;
      homing_count_r   <= homing_count_nxt;
      phase_r          <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

  `ZSP_ASSERT_NEXT(a_fault_sticky, fault_flag_r, fault_flag_r, "fault flag cleared without reset")
  `ZSP_ASSERT_SAME(a_coils_idle, out_valid_r && !out_r.driver_enable,
                   !out_r.coil_a && !out_r.coil_b, "coil driven while driver disabled")
  `ZSP_ASSERT_SAME(a_fault_not_busy, out_valid_r && out_r.fault, !out_r.busy_res,
                   "busy reported during a fault")

endmodule

FILE: sv/zsp_table_lookup.sv
// Focal length to motor coordinate lookup over the focal table.
// Depends on zsp_pkg for the tables and the alias focal length.
module zsp_table_lookup
  import zsp_pkg::*;
#(
  parameter int TABLE_ENTRIES = 10
) (
  input  logic [7:0]  focal,
  output logic        hit,
  output logic [10:0] coord
);

  always_comb begin
    hit   = 1'b0;
    coord = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (FOCAL_TAB[i] == focal) begin
        hit   = 1'b1;
        coord = COORD_TAB[i];
      end
    end
    if (focal == FOCAL_ALIAS) begin
      hit   = 1'b1;
      coord = COORD_TAB[0];
    end
  end

endmodule

FILE: tb/sv/tb_zoom_stepper_positioner_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for zoom_stepper_positioner_unit: drives control ticks, predicts
// each result from its own model of the focal table, homing and stepping, and checks them.
// Depends on zsp_pkg and the zoom_stepper_positioner_unit RTL.
module tb_zoom_stepper_positioner_unit;
  import zsp_pkg::*;

  localparam int LENS_SLOTS = 10;
  localparam bit [10:0] LENS_COORD [LENS_SLOTS] = '{
    11'd40, 11'd108, 11'd182, 11'd398, 11'd614, 11'd856, 11'd910, 11'd1000, 11'd1020, 11'd1040
  };
  localparam bit [7:0] LENS_FOCAL [LENS_SLOTS] = '{
    8'd20, 8'd24, 8'd28, 8'd35, 8'd50, 8'd70, 8'd80, 8'd105, 8'd135, 8'd200
  };
  localparam bit [1:0] COILS_FWD [4] = '{2'b10, 2'b11, 2'b01, 2'b00};
  localparam bit [1:0] COILS_BWD [4] = '{2'b00, 2'b01, 2'b11, 2'b10};
  localparam bit [7:0]  ALIAS_FOCAL   = 8'd14;
  localparam bit [7:0]  HOME_FOCAL_MM = 8'd200;
  localparam bit [10:0] COUNT_TOP     = 11'h7FF;
  localparam int        QUIET_LIMIT   = 1000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  zsp_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  zsp_out_t    out_data;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = CFG_HOME_COORD;
  logic [10:0] cfg_data = '0;

  bit [10:0] reg_home_coord = 11'd1040;
  bit [10:0] reg_step_limit = 11'd1060;
  bit        pos_homed = 1'b0;
  bit        pos_moving = 1'b0;
  bit        pos_fault = 1'b0;
  bit        pos_reverse = 1'b0;
  bit        pos_charge_lock = 1'b0;
  bit        pos_announced = 1'b0;
  bit [7:0]  pos_cur_focal = '0;
  bit [7:0]  pos_tgt_focal = '0;
  bit [10:0] pos_coord = '0;
  bit [10:0] pos_steps = '0;
  bit [1:0]  pos_phase = '0;
  bit [10:0] pos_home_count = '0;

  zsp_in_t  tick_q[$];
  zsp_out_t lens_expect_q[$];
  int       issued_items = 0;
  int       errors = 0;
  int       tx_wait = 0;
  int       rx_hold = 0;
  bit       tx_calm = 1'b0;
  bit       rx_calm = 1'b0;

  zoom_stepper_positioner_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic int focal_slot(bit [7:0] focal);
    int i;
    if (focal == ALIAS_FOCAL) return 0;
    for (i = 0; i < LENS_SLOTS; i++) begin
      if (LENS_FOCAL[i] == focal) return i;
    end
    return -1;
  endfunction

  function automatic void begin_homing(bit sw);
    pos_homed = 1'b0;
    pos_home_count = '0;
    if (!sw) begin
      pos_homed = 1'b1;
      pos_cur_focal = HOME_FOCAL_MM;
    end else begin
      pos_charge_lock = 1'b1;
      pos_reverse = 1'b0;
      pos_moving = 1'b1;
    end
  endfunction

  function automatic void plan_move(bit sw);
    bit [10:0] org;
    bit [10:0] dst;
    int slot;
    if (pos_moving) return;
    if (pos_cur_focal == pos_tgt_focal) begin
      if (pos_announced) begin
        pos_charge_lock = 1'b0;
        pos_announced = 1'b0;
      end
      return;
    end
    if (!pos_announced) begin
      pos_charge_lock = 1'b1;
      pos_announced = 1'b1;
    end
    if (pos_cur_focal == 8'd0) begin
      org = pos_coord;
    end else begin
      slot = focal_slot(pos_cur_focal);
      if (slot < 0) begin
        begin_homing(sw);
        pos_charge_lock = 1'b0;
        return;
      end
      org = LENS_COORD[slot];
    end
    slot = focal_slot(pos_tgt_focal);
    if (slot < 0) begin
      pos_tgt_focal = pos_cur_focal;
      pos_charge_lock = 1'b0;
      return;
    end
    dst = LENS_COORD[slot];
    if (dst > org) begin
      pos_reverse = 1'b0;
      pos_steps = dst - org;
    end else begin
      pos_reverse = 1'b1;
      pos_steps = org - dst;
    end
    pos_moving = 1'b1;
  endfunction

  function automatic zsp_out_t step_positioner(zsp_in_t tick);
    zsp_out_t res;
    bit [1:0] coils;
    bit       drive;
    bit       sw;
    sw = tick.home_switch;
    coils = 2'b00;
    drive = 1'b0;
    if (tick.set_dest) pos_tgt_focal = tick.dest_focal;
    if (tick.reset_cmd) begin_homing(sw);
    plan_move(sw);
    if (pos_moving && !pos_fault) begin
      if (!pos_homed) begin
        drive = 1'b1;
        if (!sw) begin
          pos_homed = 1'b1;
          pos_cur_focal = HOME_FOCAL_MM;
          pos_coord = reg_home_coord;
          pos_home_count = '0;
          pos_moving = 1'b0;
          pos_charge_lock = 1'b0;
        end else begin
          coils = COILS_FWD[pos_phase];
          pos_phase = pos_phase + 2'd1;
          if (pos_home_count > reg_step_limit) begin
            pos_fault = 1'b1;
            pos_charge_lock = 1'b0;
          end
          if (pos_home_count != COUNT_TOP) pos_home_count = pos_home_count + 11'd1;
        end
      end else if (pos_steps != 11'd0) begin
        pos_steps = pos_steps - 11'd1;
        drive = 1'b1;
        coils = pos_reverse ? COILS_BWD[pos_phase] : COILS_FWD[pos_phase];
        pos_phase = pos_phase + 2'd1;
      end else begin
        pos_cur_focal = pos_tgt_focal;
        pos_moving = 1'b0;
        pos_charge_lock = 1'b0;
      end
    end
    res.coil_a = coils[1];
    res.coil_b = coils[0];
    res.driver_enable = drive;
    res.charge_inhibit = pos_charge_lock;
    res.busy_res = pos_moving && !pos_fault;
    res.homed = pos_homed;
    res.fault = pos_fault;
    res.location = pos_cur_focal;
    return res;
  endfunction

  function automatic int pick_pause(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void queue_item(bit set_dest, bit [7:0] focal, bit reset_cmd, bit sw);
    zsp_in_t tick;
    tick.set_dest = set_dest;
    tick.dest_focal = focal;
    tick.reset_cmd = reset_cmd;
    tick.home_switch = sw;
    tick_q.push_back(tick);
    issued_items++;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  function automatic void check_result(zsp_out_t got);
    zsp_out_t want;
    if (lens_expect_q.size() == 0) begin
      errors++;
      $display("%0t: result with nothing expected, expected none, got %h", $time, got);
      return;
    end
    want = lens_expect_q.pop_front();
    check_field("coil_a", want.coil_a, got.coil_a);
    check_field("coil_b", want.coil_b, got.coil_b);
    check_field("driver_enable", want.driver_enable, got.driver_enable);
    check_field("charge_inhibit", want.charge_inhibit, got.charge_inhibit);
    check_field("busy_res", want.busy_res, got.busy_res);
    check_field("homed", want.homed, got.homed);
    check_field("fault", want.fault, got.fault);
    check_field("location", want.location, got.location);
  endfunction

  task automatic wait_quiet();
    do @(negedge clk); while (tick_q.size() != 0 || in_valid);
  endtask

  task automatic settle();
    wait_quiet();
    while (lens_expect_q.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(bit [0:0] idx, bit [10:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == CFG_HOME_COORD) reg_home_coord = value;
    else reg_step_limit = value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) lens_expect_q.push_back(step_positioner(in_data));
      if ($urandom_range(0, 199) == 0) tx_calm = !tx_calm;
      if (!in_valid || !in_stall) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_valid <= 1'b0;
        end else if (tick_q.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= tick_q.pop_front();
          tx_wait = pick_pause(tx_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) check_result(out_data);
      if ($urandom_range(0, 199) == 0) rx_calm = !rx_calm;
      if (rx_hold > 0) rx_hold--;
      else rx_hold = pick_pause(rx_calm);
      out_stall <= (rx_hold > 0);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(negedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("zoom_stepper_positioner_unit verification failed");
    $finish;
  end

  initial begin : stimulus
    int phase;
    int quota;
    int r;
    int slot;
    int dst;
    int n;
    bit sw;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    for (phase = 0; phase < 5; phase++) begin
      settle();
      case (phase)
        1: begin
          write_reg(CFG_HOME_COORD, 11'd0);
          write_reg(CFG_STEP_LIMIT, COUNT_TOP);
        end
        2: begin
          write_reg(CFG_HOME_COORD, COUNT_TOP);
          write_reg(CFG_STEP_LIMIT, 11'($urandom_range(64, 2046)));
        end
        3: begin
          write_reg(CFG_HOME_COORD, 11'($urandom_range(0, 2047)));
          write_reg(CFG_STEP_LIMIT, 11'($urandom_range(64, 2047)));
        end
        4: begin
          write_reg(CFG_HOME_COORD, 11'($urandom_range(0, 2047)));
          write_reg(CFG_STEP_LIMIT, 11'd0);
        end
        default: ;
      endcase
      if (phase == 0) begin
        queue_item(1'b0, 8'd0, 1'b0, 1'b0);
        queue_item(1'b1, 8'd255, 1'b0, 1'b1);
        queue_item(1'b0, 8'd255, 1'b0, 1'b1);
        queue_item(1'b0, 8'd0, 1'b1, 1'b1);
        queue_item(1'b0, 8'd0, 1'b0, 1'b1);
        queue_item(1'b0, 8'd0, 1'b0, 1'b0);
        queue_item(1'b0, 8'd0, 1'b1, 1'b0);
        queue_item(1'b1, HOME_FOCAL_MM, 1'b0, 1'b1);
        queue_item(1'b1, 8'd255, 1'b1, 1'b1);
        queue_item(1'b0, 8'd0, 1'b0, 1'b0);
        queue_item(1'b0, 8'd0, 1'b0, 1'b1);
        queue_item(1'b1, 8'd135, 1'b0, 1'b1);
        queue_item(1'b1, 8'd77, 1'b0, 1'b1);
      end
      if (phase == 4) begin
        // With a limit of zero a single homing step is allowed and the second one faults.
        queue_item(1'b0, 8'd0, 1'b1, 1'b1);
        queue_item(1'b0, 8'd0, 1'b0, 1'b0);
        queue_item(1'b0, 8'd0, 1'b1, 1'b1);
        queue_item(1'b0, 8'd0, 1'b0, 1'b1);
        queue_item(1'b0, 8'd0, 1'b0, 1'b1);
      end
      quota = issued_items + ((phase == 4) ? 100 : 210);
      while (issued_items < quota) begin
        wait_quiet();
        r = $urandom_range(0, 99);
        sw = ($urandom_range(0, 3) != 0);
        if (pos_fault || r < 8) begin
          n = $urandom_range(1, 4);
          repeat (n) begin
            queue_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          end
        end else if (pos_moving) begin
          n = $urandom_range(1, 12);
          repeat (n) begin
            r = $urandom_range(0, 99);
            sw = ($urandom_range(0, 3) != 0);
            if (r < 3) queue_item(1'b1, 8'($urandom_range(0, 255)), 1'b0, sw);
            else if (r < 5) queue_item(1'b0, 8'($urandom), 1'b1, sw);
            else queue_item(1'b0, 8'($urandom), 1'b0, sw);
          end
        end else if (!pos_homed || r < 25) begin
          queue_item(1'b0, 8'($urandom), 1'b1, sw);
          n = $urandom_range(0, 6);
          repeat (n) queue_item(1'b0, 8'($urandom), 1'b0, 1'b1);
          queue_item(1'b0, 8'($urandom), 1'b0, 1'b0);
        end else if (r < 35) begin
          queue_item(1'b1, pos_cur_focal, 1'b0, sw);
        end else if (r < 45) begin
          queue_item(1'b1, 8'($urandom_range(0, 255)), 1'b0, sw);
        end else begin
          slot = focal_slot(pos_cur_focal);
          if (slot < 0 || r < 50) dst = $urandom_range(0, LENS_SLOTS - 1);
          else if (slot == 0) dst = 1;
          else if (slot == LENS_SLOTS - 1) dst = slot - 1;
          else dst = ($urandom_range(0, 1) != 0) ? slot + 1 : slot - 1;
          if (dst == 0 && $urandom_range(0, 1) != 0) queue_item(1'b1, ALIAS_FOCAL, 1'b0, sw);
          else queue_item(1'b1, LENS_FOCAL[dst], 1'b0, sw);
        end
      end
    end
    settle();
    repeat (4) @(posedge clk);
    if (errors == 0 && lens_expect_q.size() == 0) begin
      $display("zoom_stepper_positioner_unit verification clean");
    end else begin
      $display("zoom_stepper_positioner_unit verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/zsp_pkg.sv
sv/zsp_table_lookup.sv
sv/zoom_stepper_positioner_unit.sv
tb/sv/tb_zoom_stepper_positioner_unit.sv
